[sv/size_class_slab_allocator_unit_assert.svh]
// Assertion macros shared by the slab allocator RTL.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SCSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab allocator check failed");
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab allocator check failed");
`else
`define SCSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/scsa_pkg.sv]
// Package with the field widths, codes and shared types of the slab allocator.
`default_nettype none
package scsa_pkg;
    localparam int MIN_BLOCK_W = 17;
    localparam int CLASS_COUNT_W = 4;
    localparam int SEG_BYTES_W = 23;
    localparam int HDR_BYTES_W = 9;
    localparam int SIZE_W = 24;
    localparam int FCLASS_W = 3;
    localparam int FBLOCK_W = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [MIN_BLOCK_W-1:0] MIN_BLOCK_RST = 17'd64;
    localparam logic [CLASS_COUNT_W-1:0] CLASS_COUNT_RST = 4'd8;
    localparam logic [SEG_BYTES_W-1:0] SEG_BYTES_RST = 23'(1024 * 1024 * 2);
    localparam logic [HDR_BYTES_W-1:0] HDR_BYTES_RST = 9'd64;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOCK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_BYTES = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_BYTES = 8'd3;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEM = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

[sv/scsa_if.sv]
// Handshake interfaces for the request, response and configuration channels.
`default_nettype none
interface scsa_req_if import scsa_pkg::*; ();
    logic valid;
    logic ready;
    logic func;
    logic [SIZE_W-1:0] size;
    logic [FCLASS_W-1:0] free_class;
    logic [FBLOCK_W-1:0] free_block;
    modport source (output valid, func, size, free_class, free_block, input ready);
    modport sink (input valid, func, size, free_class, free_block, output ready);
endinterface

interface scsa_rsp_if import scsa_pkg::*; ();
    logic valid;
    logic ready;
    logic [STATUS_W-1:0] status;
    logic [FCLASS_W-1:0] out_class;
    logic [FBLOCK_W-1:0] out_block;
    modport source (output valid, status, out_class, out_block, input ready);
    modport sink (input valid, status, out_class, out_block, output ready);
endinterface

interface scsa_cfg_if import scsa_pkg::*; ();
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/size_class_slab_allocator_unit.sv]
// Top level of the power-of-two size-class slab allocator.
// The block accepts a new request word only in its idle state. A free passes through the
// free state and the response state before its response is registered. An allocate first
// walks the size classes one per cycle, then takes a block from the carve run or from a free
// list with one entry, or also goes through the pop state for a longer free list, whose next
// pointer comes from a RAM with registered read. When a class runs empty, opening a segment
// runs 23 divider steps, then reads the quotient and goes back to the take state.
// The response sits in an output register, so a new request is taken
// while the previous response is still waiting.
`default_nettype none
`include "size_class_slab_allocator_unit_assert.svh"
module size_class_slab_allocator_unit import scsa_pkg::*; #(
    parameter int CLASSES = 8,
    parameter int SEGS_MAX = 16,
    parameter int POOL_DEPTH = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    scsa_req_if.sink   i_req,
    scsa_rsp_if.source o_rsp,
    scsa_cfg_if.sink   i_cfg
);
    localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int CIW = $clog2(CLASSES + 1);
    localparam int BW = $clog2(POOL_DEPTH);
    localparam int NW = $clog2(POOL_DEPTH + 1);
    localparam int SW = $clog2(SEGS_MAX + 1);
    localparam int BSW = MIN_BLOCK_W + CLASSES - 1;
    localparam int DW = BSW + 1;
    localparam int AW = $clog2(CLASSES * POOL_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_TAKE = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_POP = 3'd4;
    localparam logic [2:0] S_FREE = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [MIN_BLOCK_W-1:0] r_min_block;
    logic [CLASS_COUNT_W-1:0] r_class_count;
    logic [SEG_BYTES_W-1:0] r_seg_bytes;
    logic [HDR_BYTES_W-1:0] r_hdr_bytes;

    logic [BW-1:0] r_head [CLASSES];
    logic [BW-1:0] r_tail [CLASSES];
    logic [CLASSES-1:0] r_ne;
    logic [SW-1:0] r_segs [CLASSES];
    logic [NW-1:0] r_cn [CLASSES];
    logic [NW-1:0] r_cl [CLASSES];

    logic [2:0] r_state;
    logic [CIW-1:0] r_idx;
    logic [CIW-1:0] r_ncls;
    logic [BSW-1:0] r_bsz;
    logic [SIZE_W-1:0] r_size;
    logic [NW-1:0] r_fblk;
    logic r_fbad;
    logic [BW-1:0] r_blk;
    logic [STATUS_W-1:0] r_res_st;
    logic [BW-1:0] r_res_blk;
    logic [CIW-1:0] r_res_cls;

    logic r_rsp_valid;
    logic [STATUS_W-1:0] r_rsp_st;
    logic [FCLASS_W-1:0] r_rsp_cls;
    logic [FBLOCK_W-1:0] r_rsp_blk;

    logic [CW-1:0] cls;
    logic [DW-1:0] divisor;
    logic div_start;
    t_div_stat div_stat;
    logic [SEG_BYTES_W-1:0] quo;
    logic [NW-1:0] room;
    logic [NW-1:0] cnt;
    logic ram_we;
    logic ram_re;
    logic [AW-1:0] ram_addr;
    logic [BW-1:0] ram_rdata;

    assign cls = r_idx[CW-1:0];
    assign divisor = DW'(r_bsz) + DW'(r_hdr_bytes);
    assign div_start = (r_state == S_TAKE) && (r_cl[cls] == '0) && !r_ne[cls] &&
                       (32'(r_segs[cls]) < SEGS_MAX);
    assign room = NW'(POOL_DEPTH) - r_cn[cls];
    assign cnt = (divisor == '0) ? '0 :
                 ((32'(quo) > 32'(room)) ? room : NW'(quo));
    assign ram_re = (r_state == S_TAKE) && (r_cl[cls] == '0) && r_ne[cls] &&
                    (r_head[cls] != r_tail[cls]);
    assign ram_we = (r_state == S_FREE) && !r_fbad && (r_fblk < r_cn[cls]) && r_ne[cls];
    assign ram_addr = AW'(cls) * AW'(POOL_DEPTH) +
                      AW'(ram_we ? r_tail[cls] : r_head[cls]);

    scsa_div #(
        .NUM_W(SEG_BYTES_W),
        .DEN_W(DW)
    ) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num(r_seg_bytes),
        .i_den(divisor),
        .o_stat(div_stat),
        .o_quo(quo)
    );

    scsa_ram #(
        .WIDTH(BW),
        .DEPTH(CLASSES * POOL_DEPTH)
    ) u_link_ram (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(ram_addr),
        .i_wdata(BW'(r_fblk)),
        .i_re(ram_re),
        .i_raddr(ram_addr),
        .o_rdata(ram_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_block <= MIN_BLOCK_RST;
            r_class_count <= CLASS_COUNT_RST;
            r_seg_bytes <= SEG_BYTES_RST;
            r_hdr_bytes <= HDR_BYTES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_BLOCK: r_min_block <= i_cfg.data[MIN_BLOCK_W-1:0];
                REG_CLASS_COUNT: r_class_count <= i_cfg.data[CLASS_COUNT_W-1:0];
                REG_SEG_BYTES: r_seg_bytes <= i_cfg.data[SEG_BYTES_W-1:0];
                REG_HDR_BYTES: r_hdr_bytes <= i_cfg.data[HDR_BYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ne <= '0;
            for (int c = 0; c < CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_segs[c] <= '0;
                r_cn[c] <= '0;
                r_cl[c] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_size <= i_req.size;
                        r_fblk <= NW'(i_req.free_block);
                        r_fbad <= (32'(i_req.free_class) >= CLASSES) ||
                                  (32'(i_req.free_block) >= POOL_DEPTH);
                        r_bsz <= BSW'(r_min_block);
                        r_ncls <= (32'(r_class_count) > CLASSES) ?
                                  CIW'(CLASSES) : CIW'(r_class_count);
                        r_res_st <= ST_OK;
                        r_res_cls <= '0;
                        r_res_blk <= '0;
                        if (i_req.func == FN_FREE) begin
                            r_idx <= CIW'(i_req.free_class);
                            r_state <= S_FREE;
                        end else begin
                            r_idx <= '0;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (r_idx >= r_ncls) begin
                        r_res_st <= ST_TOO_BIG;
                        r_state <= S_RESP;
                    end else if (32'(r_bsz) >= 32'(r_size)) begin
                        r_state <= S_TAKE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_bsz <= r_bsz << 1;
                    end
                end
                S_TAKE: begin
                    if (r_cl[cls] != '0) begin
                        r_res_blk <= BW'(r_cn[cls]);
                        r_res_cls <= r_idx;
                        r_cn[cls] <= r_cn[cls] + 1'b1;
                        r_cl[cls] <= r_cl[cls] - 1'b1;
                        r_state <= S_RESP;
                    end else if (r_ne[cls]) begin
                        r_res_blk <= r_head[cls];
                        r_res_cls <= r_idx;
                        if (r_head[cls] == r_tail[cls]) begin
                            r_ne[cls] <= 1'b0;
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_res_st <= ST_NO_MEM;
                        r_state <= S_RESP;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (cnt == '0) begin
                            r_res_st <= ST_NO_MEM;
                            r_state <= S_RESP;
                        end else begin
                            r_segs[cls] <= r_segs[cls] + 1'b1;
                            r_cl[cls] <= cnt;
                            r_state <= S_TAKE;
                        end
                    end
                end
                S_POP: begin
                    r_head[cls] <= ram_rdata;
                    r_state <= S_RESP;
                end
                S_FREE: begin
                    if (!r_fbad && r_fblk < r_cn[cls]) begin
                        r_tail[cls] <= BW'(r_fblk);
                        if (!r_ne[cls]) begin
                            r_head[cls] <= BW'(r_fblk);
                            r_ne[cls] <= 1'b1;
                        end
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (r_state == S_RESP && (!r_rsp_valid || o_rsp.ready)) begin
            r_rsp_valid <= 1'b1;
            r_rsp_st <= r_res_st;
            r_rsp_cls <= (r_res_st == ST_OK) ? FCLASS_W'(r_res_cls) : '0;
            r_rsp_blk <= (r_res_st == ST_OK) ? FBLOCK_W'(r_res_blk) : '0;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.status = r_rsp_st;
    assign o_rsp.out_class = r_rsp_cls;
    assign o_rsp.out_block = r_rsp_blk;

    `SCSA_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, r_state == S_POP, r_ne[cls])
    `SCSA_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    `SCSA_ASSERT_NOW(a_carve_in_pool, i_clk, i_rst_n, r_state == S_TAKE,
        32'(r_cl[cls]) + 32'(r_cn[cls]) <= POOL_DEPTH)
    `SCSA_ASSERT_NOW(a_no_ram_collision, i_clk, i_rst_n, ram_we, !ram_re)
endmodule
`default_nettype wire

[sv/scsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module scsa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[sv/scsa_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
`include "size_class_slab_allocator_unit_assert.svh"
module scsa_div import scsa_pkg::*; #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output t_div_stat             o_stat,
    output logic      [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic [DEN_W:0] shifted;
    logic fits;

    assign shifted = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign fits = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? shifted - {1'b0, r_den} : shifted;
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo = r_quo;

    `SCSA_ASSERT_NEXT(a_done_ends_busy, i_clk, i_rst_n, r_done, !r_busy || $past(i_start))
    `SCSA_ASSERT_NOW(a_busy_has_count, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `SCSA_ASSERT_NEXT(a_last_bit_done, i_clk, i_rst_n,
        r_busy && !i_start && r_cnt == CNT_W'(1), r_done)
endmodule
`default_nettype wire

[test/tb_size_class_slab_allocator_unit.sv]
// Self-checking testbench for the size-class slab allocator with a built-in allocation predictor.
module tb_size_class_slab_allocator_unit;
    import scsa_pkg::*;

    localparam int NCLS = 8;
    localparam int SEG_LIMIT = 16;
    localparam int DEPTH = 4096;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FCLASS_W-1:0] cls;
        logic [FBLOCK_W-1:0] blk;
    } t_alloc_word;

    class alloc_scoreboard;
        logic [MIN_BLOCK_W-1:0] min_blk;
        logic [CLASS_COUNT_W-1:0] cls_cnt;
        logic [SEG_BYTES_W-1:0] seg_bytes;
        logic [HDR_BYTES_W-1:0] hdr_bytes;
        logic [FBLOCK_W-1:0] link_mem[NCLS][DEPTH];
        logic [FBLOCK_W-1:0] head[NCLS];
        logic [FBLOCK_W-1:0] tail[NCLS];
        bit nonempty[NCLS];
        int segs[NCLS];
        int carve_nxt[NCLS];
        int carve_lft[NCLS];
        int live[NCLS][$];
        t_alloc_word pending[$];
        int errors;

        function new();
            min_blk = MIN_BLOCK_RST;
            cls_cnt = CLASS_COUNT_RST;
            seg_bytes = SEG_BYTES_RST;
            hdr_bytes = HDR_BYTES_RST;
            errors = 0;
            for (int c = 0; c < NCLS; c++) begin
                head[c] = '0;
                tail[c] = '0;
                nonempty[c] = 0;
                segs[c] = 0;
                carve_nxt[c] = 0;
                carve_lft[c] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MIN_BLOCK: min_blk = val[MIN_BLOCK_W-1:0];
                REG_CLASS_COUNT: cls_cnt = val[CLASS_COUNT_W-1:0];
                REG_SEG_BYTES: seg_bytes = val[SEG_BYTES_W-1:0];
                REG_HDR_BYTES: hdr_bytes = val[HDR_BYTES_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [STATUS_W-1:0] take_block(int c, output logic [FBLOCK_W-1:0] blk);
            logic [63:0] divisor;
            logic [63:0] cnt;
            logic [63:0] room;
            blk = '0;
            if (carve_lft[c] == 0 && !nonempty[c]) begin
                divisor = (64'(min_blk) << c) + 64'(hdr_bytes);
                cnt = (divisor != 0) ? 64'(seg_bytes) / divisor : 64'd0;
                room = 64'(DEPTH - carve_nxt[c]);
                if (segs[c] >= SEG_LIMIT) return ST_NO_MEM;
                if (cnt > room) cnt = room;
                if (cnt == 0) return ST_NO_MEM;
                segs[c]++;
                carve_lft[c] = int'(cnt);
            end
            if (carve_lft[c] != 0) begin
                blk = FBLOCK_W'(carve_nxt[c]);
                carve_nxt[c]++;
                carve_lft[c]--;
                return ST_OK;
            end
            blk = head[c];
            if (head[c] == tail[c]) nonempty[c] = 0;
            else head[c] = link_mem[c][head[c]];
            return ST_OK;
        endfunction

        function void note_request(logic fn, logic [SIZE_W-1:0] sz,
                                   logic [FCLASS_W-1:0] fc, logic [FBLOCK_W-1:0] fb);
            t_alloc_word w;
            int n;
            logic [FBLOCK_W-1:0] blk;
            w.status = ST_OK;
            w.cls = '0;
            w.blk = '0;
            if (fn == FN_FREE) begin
                if (int'(fb) < carve_nxt[fc]) begin
                    if (nonempty[fc]) begin
                        link_mem[fc][tail[fc]] = fb;
                        tail[fc] = fb;
                    end else begin
                        head[fc] = fb;
                        tail[fc] = fb;
                        nonempty[fc] = 1;
                    end
                end
            end else begin
                n = (cls_cnt > NCLS) ? NCLS : int'(cls_cnt);
                w.status = ST_TOO_BIG;
                for (int i = 0; i < n; i++) begin
                    if ((64'(min_blk) << i) >= 64'(sz)) begin
                        w.status = take_block(i, blk);
                        if (w.status == ST_OK) begin
                            w.cls = FCLASS_W'(i);
                            w.blk = blk;
                            live[i].push_back(int'(blk));
                        end
                        break;
                    end
                end
            end
            pending.push_back(w);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [FCLASS_W-1:0] c,
                          logic [FBLOCK_W-1:0] b);
            t_alloc_word w;
            if (pending.size() == 0) begin
                report("unexpected response word", int'(st), -1);
            end else begin
                w = pending.pop_front();
                if (st !== w.status) report("status", int'(st), int'(w.status));
                if (c !== w.cls) report("out_class", int'(c), int'(w.cls));
                if (b !== w.blk) report("out_block", int'(b), int'(w.blk));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit no_idle;
    int hold_cnt;
    int hold_seen;
    int hold_left;
    int cycles;
    alloc_scoreboard sb;

    scsa_req_if req_ch();
    scsa_rsp_if rsp_ch();
    scsa_cfg_if cfg_ch();

    size_class_slab_allocator_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_cnt != hold_seen) begin
            hold_seen <= hold_cnt;
            hold_left <= 400;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 33);
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.out_class, rsp_ch.out_block);
    end

    task send(logic fn, logic [SIZE_W-1:0] sz, logic [FCLASS_W-1:0] fc,
              logic [FBLOCK_W-1:0] fb);
        if (!no_idle && $urandom_range(99) < 33) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= fn;
        req_ch.size <= sz;
        req_ch.free_class <= fc;
        req_ch.free_block <= fb;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(fn, sz, fc, fb);
    endtask

    task drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task configure(int mb, int cc, int seg, int hdr);
        drain();
        write_reg(REG_MIN_BLOCK, mb);
        write_reg(REG_CLASS_COUNT, cc);
        write_reg(REG_SEG_BYTES, seg);
        write_reg(REG_HDR_BYTES, hdr);
    endtask

    task random_traffic(int count);
        int r;
        int k;
        int c;
        int j;
        longint lim;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            c = $urandom_range(NCLS - 1);
            if (r < 55) begin
                k = $urandom_range(NCLS - 1);
                lim = longint'(sb.min_blk) << k;
                if (lim > 64'hFFFFFF) lim = 64'hFFFFFF;
                send(FN_ALLOC, SIZE_W'($urandom_range(0, int'(lim))), '0, '0);
            end else if (r < 88 && sb.live[c].size() > 0) begin
                j = $urandom_range(sb.live[c].size() - 1);
                send(FN_FREE, SIZE_W'($urandom), FCLASS_W'(c), FBLOCK_W'(sb.live[c][j]));
                if ($urandom_range(9) != 0) sb.live[c].delete(j);
            end else begin
                send(1'($urandom), SIZE_W'($urandom), FCLASS_W'($urandom),
                     FBLOCK_W'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_cnt = 0;
        hold_seen = 0;
        hold_left = 0;
        no_idle = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_ALLOC;
        req_ch.size = '0;
        req_ch.free_class = '0;
        req_ch.free_block = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MIN_BLOCK;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(FN_ALLOC, 24'd0, '0, '0);
        send(FN_ALLOC, 24'd1, '0, '0);
        send(FN_ALLOC, 24'd64, '0, '0);
        send(FN_ALLOC, 24'd65, '0, '0);
        send(FN_ALLOC, 24'd8192, '0, '0);
        send(FN_ALLOC, 24'd8193, '0, '0);
        send(FN_ALLOC, 24'hFFFFFF, '0, '0);
        send(FN_FREE, 24'hFFFFFF, 3'd0, 12'd0);
        send(FN_FREE, '0, 3'd0, 12'd0);
        send(FN_FREE, '0, 3'd0, 12'd4095);
        send(FN_FREE, '0, 3'd7, 12'd0);
        send(FN_FREE, '0, 3'd3, 12'd5);
        send(FN_ALLOC, 24'd1, '0, '0);

        // Tiny segments: the free list and the segment limit are reached quickly.
        configure(1, 4, 4096, 256);
        for (int i = 0; i < 245; i++) send(FN_ALLOC, 24'd1, '0, '0);
        hold_cnt <= hold_cnt + 1;
        random_traffic(250);

        // One huge segment is capped at the index space of class 0.
        configure(1, 1, 4194304, 0);
        no_idle = 1;
        for (int i = 0; i < 200; i++) send(FN_ALLOC, 24'd0, '0, '0);
        no_idle = 0;

        configure(65536, 15, 4194304, 0);
        random_traffic(80);
        configure(0, 0, 4096, 0);
        send(FN_ALLOC, 24'd0, '0, '0);
        configure(0, 2, 8388607, 0);
        send(FN_ALLOC, 24'd0, '0, '0);
        send(FN_ALLOC, 24'd1, '0, '0);
        configure(131071, 8, 4096, 256);
        random_traffic(80);

        for (int p = 0; p < 4; p++) begin
            configure($urandom_range(1, 600), $urandom_range(0, 15),
                      $urandom_range(4096, 8388607), $urandom_range(0, 511));
            random_traffic(100);
        end

        drain();
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
